>>> src/dec_pkg.sv
// Shared types, constants and the microcode program of the directed Euler classifier.
`default_nettype none

package dec_pkg;

    localparam int MAX_VERTICES = 16;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
    localparam int PC_W         = 3;
    localparam int CLASS_W      = 2;

    localparam logic [CNT_W-1:0] VCOUNT_RESET = CNT_W'(MAX_VERTICES);

    localparam logic [CLASS_W-1:0] CLASS_NONE    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_CIRCUIT = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_PATH    = 2'd2;

    // Program step addresses
    localparam logic [PC_W-1:0] STEP_LOAD  = 3'd0;
    localparam logic [PC_W-1:0] STEP_INIT  = 3'd1;
    localparam logic [PC_W-1:0] STEP_CLOSE = 3'd2;
    localparam logic [PC_W-1:0] STEP_CONN  = 3'd3;
    localparam logic [PC_W-1:0] STEP_INDEG = 3'd4;
    localparam logic [PC_W-1:0] STEP_DEG   = 3'd5;
    localparam logic [PC_W-1:0] STEP_EMIT  = 3'd6;
    localparam logic [PC_W-1:0] STEP_CLEAR = 3'd7;

    typedef enum logic [2:0] {
        OP_LOAD,
        OP_INIT,
        OP_CLOSE,
        OP_CONN,
        OP_INDEG,
        OP_DEG,
        OP_EMIT,
        OP_CLEAR
    } op_t;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_START,
        C_CLOSE_MORE,
        C_CONN_BAD,
        C_VTX_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        logic start;
        logic close_more;
        logic conn_bad;
        logic vtx_more;
        logic out_busy;
    } status_t;

    // Jump to target when the condition holds, else fall through to the next step.
    function automatic ctrl_word_t program_word(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = '{op: OP_LOAD, cond: C_NO_START, target: STEP_LOAD};
        case (pc)
            STEP_LOAD:  w = '{op: OP_LOAD,  cond: C_NO_START,   target: STEP_LOAD};
            STEP_INIT:  w = '{op: OP_INIT,  cond: C_ALWAYS,     target: STEP_CLOSE};
            STEP_CLOSE: w = '{op: OP_CLOSE, cond: C_CLOSE_MORE, target: STEP_CLOSE};
            STEP_CONN:  w = '{op: OP_CONN,  cond: C_CONN_BAD,   target: STEP_EMIT};
            STEP_INDEG: w = '{op: OP_INDEG, cond: C_VTX_MORE,   target: STEP_INDEG};
            STEP_DEG:   w = '{op: OP_DEG,   cond: C_VTX_MORE,   target: STEP_DEG};
            STEP_EMIT:  w = '{op: OP_EMIT,  cond: C_OUT_BUSY,   target: STEP_EMIT};
            STEP_CLEAR: w = '{op: OP_CLEAR, cond: C_ALWAYS,     target: STEP_LOAD};
            default:    w = '{op: OP_LOAD,  cond: C_NO_START,   target: STEP_LOAD};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> src/dec_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
`default_nettype none

module dec_seq (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire dec_pkg::status_t    status,
    output dec_pkg::ctrl_word_t      cw
);
    import dec_pkg::*;

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            taken;

    assign cw = program_word(pc_reg);

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:     taken = 1'b1;
            C_NO_START:   taken = !status.start;
            C_CLOSE_MORE: taken = status.close_more;
            C_CONN_BAD:   taken = status.conn_bad;
            C_VTX_MORE:   taken = status.vtx_more;
            C_OUT_BUSY:   taken = status.out_busy;
            default:      taken = 1'b0;
        endcase
        pc_next = taken ? cw.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_LOAD;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

>>> src/dec_datapath.sv
// Datapath: adjacency store, closure set, in-degree counters and trail checks.
`default_nettype none

module dec_datapath (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire dec_pkg::ctrl_word_t     cw,
    input  wire                          row_fire,
    input  wire [dec_pkg::VTX_W-1:0]     row_index,
    input  wire [dec_pkg::MAX_VERTICES-1:0] row_bits,
    input  wire [dec_pkg::CNT_W-1:0]     vertex_count,
    input  wire                          out_free,
    output logic                         conn_bad,
    output logic                         vtx_more,
    output logic                         close_more,
    output logic                         emit,
    output logic [dec_pkg::CLASS_W-1:0]  class_value
);
    import dec_pkg::*;

    logic [MAX_VERTICES-1:0] adj_reg   [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] adj_next  [MAX_VERTICES];
    logic [CNT_W-1:0]        indeg_reg [MAX_VERTICES];
    logic [CNT_W-1:0]        indeg_next[MAX_VERTICES];
    logic [MAX_VERTICES-1:0] reached_reg, reached_next;
    logic [VTX_W-1:0]        vtx_reg, vtx_next;
    logic [VTX_W-1:0]        sweep_reg, sweep_next;
    logic [CNT_W-1:0]        starts_reg, starts_next;
    logic [CNT_W-1:0]        ends_reg, ends_next;
    logic                    fail_reg, fail_next;

    logic [CNT_W-1:0]        n_eff;
    logic [MAX_VERTICES-1:0] mask;
    logic [MAX_VERTICES-1:0] cur_row;
    logic [MAX_VERTICES-1:0] vtx_bit;
    logic [CNT_W-1:0]        dout;
    logic [CNT_W-1:0]        din;
    logic                    vtx_active;
    logic                    vtx_last;
    logic                    sweep_last;

    // Clamp the vertex count into 1..MAX_VERTICES
    always_comb
    begin
        if (vertex_count == '0)
            n_eff = CNT_W'(1);
        else if (vertex_count > CNT_W'(MAX_VERTICES))
            n_eff = CNT_W'(MAX_VERTICES);
        else
            n_eff = vertex_count;
        for (int j = 0; j < MAX_VERTICES; j++)
            mask[j] = CNT_W'(j) < n_eff;
    end

    assign cur_row    = adj_reg[vtx_reg] & mask;
    assign vtx_bit    = MAX_VERTICES'(1) << vtx_reg;
    assign vtx_active = {1'b0, vtx_reg} < n_eff;
    assign vtx_last   = vtx_reg == VTX_W'(MAX_VERTICES - 1);
    assign sweep_last = sweep_reg == VTX_W'(MAX_VERTICES - 1);
    assign din        = indeg_reg[vtx_reg];

    always_comb
    begin
        dout = '0;
        for (int j = 0; j < MAX_VERTICES; j++)
            dout = dout + CNT_W'(cur_row[j]);
    end

    assign conn_bad   = reached_reg != mask;
    assign vtx_more   = !vtx_last;
    assign close_more = !(vtx_last && sweep_last);
    assign emit       = (cw.op == OP_EMIT) && out_free;

    always_comb
    begin
        if (fail_reg)
            class_value = CLASS_NONE;
        else if (starts_reg == '0 && ends_reg == '0)
            class_value = CLASS_CIRCUIT;
        else if (starts_reg == CNT_W'(1) && ends_reg == CNT_W'(1))
            class_value = CLASS_PATH;
        else
            class_value = CLASS_NONE;
    end

    always_comb
    begin
        adj_next     = adj_reg;
        indeg_next   = indeg_reg;
        reached_next = reached_reg;
        vtx_next     = vtx_reg;
        sweep_next   = sweep_reg;
        starts_next  = starts_reg;
        ends_next    = ends_reg;
        fail_next    = fail_reg;

        case (cw.op)
            OP_LOAD:
            begin
                if (row_fire && ({1'b0, row_index} < CNT_W'(MAX_VERTICES)))
                    adj_next[row_index] = row_bits;
            end
            OP_INIT:
            begin
                reached_next = MAX_VERTICES'(1);
                vtx_next     = '0;
                sweep_next   = '0;
                starts_next  = '0;
                ends_next    = '0;
                fail_next    = 1'b0;
                for (int j = 0; j < MAX_VERTICES; j++)
                    indeg_next[j] = '0;
            end
            OP_CLOSE:
            begin
                // Grow the set along out-edges of a reached vertex and back along
                // any edge into the set, so the graph is seen undirected.
                if (vtx_active)
                begin
                    if ((reached_reg & vtx_bit) != '0)
                        reached_next = reached_next | cur_row;
                    if ((cur_row & reached_reg) != '0)
                        reached_next = reached_next | vtx_bit;
                end
                vtx_next = vtx_reg + 1'b1;
                if (vtx_last)
                    sweep_next = sweep_reg + 1'b1;
            end
            OP_CONN:
            begin
                fail_next = conn_bad;
                vtx_next  = '0;
            end
            OP_INDEG:
            begin
                if (vtx_active)
                begin
                    for (int j = 0; j < MAX_VERTICES; j++)
                        if (cur_row[j])
                            indeg_next[j] = indeg_reg[j] + 1'b1;
                end
                vtx_next = vtx_reg + 1'b1;
            end
            OP_DEG:
            begin
                if (vtx_active)
                begin
                    if ({1'b0, dout} == {1'b0, din} + 1'b1)
                        starts_next = starts_reg + 1'b1;
                    else if ({1'b0, din} == {1'b0, dout} + 1'b1)
                        ends_next = ends_reg + 1'b1;
                    else if (din != dout)
                        fail_next = 1'b1;
                end
                vtx_next = vtx_reg + 1'b1;
            end
            OP_EMIT:
            begin
            end
            OP_CLEAR:
            begin
                reached_next = '0;
                for (int j = 0; j < MAX_VERTICES; j++)
                    adj_next[j] = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < MAX_VERTICES; j++)
            begin
                adj_reg[j]   <= '0;
                indeg_reg[j] <= '0;
            end
            reached_reg <= '0;
            vtx_reg     <= '0;
            sweep_reg   <= '0;
            starts_reg  <= '0;
            ends_reg    <= '0;
            fail_reg    <= 1'b0;
        end
        else
        begin
            adj_reg     <= adj_next;
            indeg_reg   <= indeg_next;
            reached_reg <= reached_next;
            vtx_reg     <= vtx_next;
            sweep_reg   <= sweep_next;
            starts_reg  <= starts_next;
            ends_reg    <= ends_next;
            fail_reg    <= fail_next;
        end
    end

endmodule

`default_nettype wire

>>> src/directed_euler_classifier.sv
// Top level of the directed Euler classifier: ports, config register, result register.
// Rows are taken only at the load step. After the last row: init, closure, connectivity
//   check, in-degree and degree passes, then emit (a graph not weakly connected skips to emit).
// Emit waits for a free output; no new graph is taken until clear returns to load. The closure
//   pass of 16 sweeps over 16 rows, one row read per cycle, takes most of the classify time.
// Reset: rst_n clears the store, the sequencer and the result register; vertex_count = 16.
`default_nettype none

module directed_euler_classifier (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [dec_pkg::CNT_W-1:0]         cfg_data,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire [dec_pkg::VTX_W-1:0]         row_index,
    input  wire [dec_pkg::MAX_VERTICES-1:0]  row_bits,
    input  wire                              last_row,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [dec_pkg::CLASS_W-1:0]      euler_class
);
    import dec_pkg::*;

    ctrl_word_t          cw;
    status_t             status;
    logic [CNT_W-1:0]    vcount_reg, vcount_next;
    logic                out_valid_reg, out_valid_next;
    logic [CLASS_W-1:0]  class_reg, class_next;
    logic                row_fire;
    logic                out_free;
    logic                emit;
    logic                conn_bad;
    logic                vtx_more;
    logic                close_more;
    logic [CLASS_W-1:0]  class_value;

    // Config is always taken; the user must write it only while the block is idle, the block does not enforce it.
    assign cfg_ready   = 1'b1;
    assign vcount_next = (cfg_valid && cfg_ready) ? cfg_data : vcount_reg;

    // Rows are taken only while the program sits at its load step.
    assign in_ready = cw.op == OP_LOAD;
    assign row_fire = in_valid && in_ready;

    // The result register frees up in the same cycle its beat is taken.
    assign out_free = !out_valid_reg || out_ready;

    assign status.start      = row_fire && last_row;
    assign status.close_more = close_more;
    assign status.conn_bad   = conn_bad;
    assign status.vtx_more   = vtx_more;
    assign status.out_busy   = !out_free;

    dec_seq u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cw     (cw)
    );

    dec_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cw           (cw),
        .row_fire     (row_fire),
        .row_index    (row_index),
        .row_bits     (row_bits),
        .vertex_count (vcount_reg),
        .out_free     (out_free),
        .conn_bad     (conn_bad),
        .vtx_more     (vtx_more),
        .close_more   (close_more),
        .emit         (emit),
        .class_value  (class_value)
    );

    // Load the result beat on emit, drop valid once it is taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        class_next     = class_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            class_next     = class_value;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VCOUNT_RESET;
            out_valid_reg <= 1'b0;
            class_reg     <= CLASS_NONE;
        end
        else
        begin
            vcount_reg    <= vcount_next;
            out_valid_reg <= out_valid_next;
            class_reg     <= class_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign euler_class = class_reg;

endmodule

`default_nettype wire

>>> src/dec_checker.sv
// Port-level checker for the directed Euler classifier, bound to the top level.
`default_nettype none

module dec_checker (
    input wire                              clk,
    input wire                              rst_n,
    input wire                              cfg_valid,
    input wire                              cfg_ready,
    input wire [dec_pkg::CNT_W-1:0]         cfg_data,
    input wire                              in_valid,
    input wire                              in_ready,
    input wire [dec_pkg::VTX_W-1:0]         row_index,
    input wire [dec_pkg::MAX_VERTICES-1:0]  row_bits,
    input wire                              last_row,
    input wire                              out_valid,
    input wire                              out_ready,
    input wire [dec_pkg::CLASS_W-1:0]       euler_class
);
    import dec_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(euler_class))
        else $error("result beat changed while stalled");

    // Only the three defined classes appear.
    a_class_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (euler_class == CLASS_NONE || euler_class == CLASS_CIRCUIT ||
                       euler_class == CLASS_PATH))
        else $error("undefined class code");

    // After the last row the block stops taking rows while it classifies.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_row |=> !in_ready)
        else $error("row taken right after last row");

    // A result never follows the last row in the next cycle.
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_row |=> !$rose(out_valid))
        else $error("result appeared too early");

    // A config beat is taken on its first offer.
    a_cfg_open: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind directed_euler_classifier dec_checker u_dec_checker (.*);

`default_nettype wire

>>> verif/euler_class_checker.sv
// Checker for the directed Euler classifier: tracks the graph store, predicts and compares.
module euler_class_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [dec_pkg::CNT_W-1:0]        cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [dec_pkg::VTX_W-1:0]        row_index,
    input  logic [dec_pkg::MAX_VERTICES-1:0] row_bits,
    input  logic                             last_row,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic [dec_pkg::CLASS_W-1:0]      euler_class,
    output int                               mismatches,
    output int                               pending
);
    import dec_pkg::*;

    localparam int NV = MAX_VERTICES;

    logic [CNT_W-1:0]   vertex_count;
    logic [NV-1:0]      stored_rows [NV];
    logic [CLASS_W-1:0] expected_class_q [$];
    int                 fail_count = 0;

    // Weak connectivity from vertex 0, then the in/out degree balance of every vertex in use.
    function automatic logic [CLASS_W-1:0] classify_graph(input logic [CNT_W-1:0] count);
        int            n;
        int            v;
        int            u;
        int            sweep;
        int            sources;
        int            sinks;
        int            dout;
        int            din;
        logic [NV-1:0] mask;
        logic [NV-1:0] reach;
        logic [NV-1:0] grow;
        logic [NV-1:0] undirected [NV];
        n = (count == 0) ? 1 : ((count > NV) ? NV : int'(count));
        mask = '0;
        for (v = 0; v < n; v++)
            mask[v] = 1'b1;
        for (v = 0; v < n; v++)
            undirected[v] = stored_rows[v] & mask;
        for (u = 0; u < n; u++)
            for (v = 0; v < n; v++)
                if (stored_rows[u][v])
                    undirected[v][u] = 1'b1;
        reach = NV'(1);
        for (sweep = 0; sweep < n; sweep++)
        begin
            grow = reach;
            for (v = 0; v < n; v++)
                if (reach[v])
                    grow |= undirected[v];
            reach = grow & mask;
        end
        if (reach != mask)
            return CLASS_NONE;
        sources = 0;
        sinks = 0;
        for (v = 0; v < n; v++)
        begin
            dout = $countones(stored_rows[v] & mask);
            din = 0;
            for (u = 0; u < n; u++)
                din += int'(stored_rows[u][v]);
            if (dout == din + 1)
                sources++;
            else if (din == dout + 1)
                sinks++;
            else if (din != dout)
                return CLASS_NONE;
        end
        if (sources == 0 && sinks == 0)
            return CLASS_CIRCUIT;
        if (sources == 1 && sinks == 1)
            return CLASS_PATH;
        return CLASS_NONE;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        logic [CLASS_W-1:0] want;
        if (!rst_n)
        begin
            vertex_count = VCOUNT_RESET;
            for (int i = 0; i < NV; i++)
                stored_rows[i] = '0;
            expected_class_q.delete();
        end
        else
        begin
            // compare first: a result never belongs to a graph closed on the same edge
            if (out_valid && out_ready)
            begin
                if (expected_class_q.size() == 0)
                begin
                    $error("euler_class beat with no result expected: actual %0d", euler_class);
                    fail_count++;
                end
                else
                begin
                    want = expected_class_q.pop_front();
                    if (euler_class !== want)
                    begin
                        $error("euler_class mismatch: expected %0d, actual %0d",
                               want, euler_class);
                        fail_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                vertex_count = cfg_data;
            if (in_valid && in_ready)
            begin
                stored_rows[row_index] = row_bits;
                if (last_row)
                begin
                    want = classify_graph(vertex_count);
                    expected_class_q.insert(expected_class_q.size(), want);
                    for (int i = 0; i < NV; i++)
                        stored_rows[i] = '0;
                end
            end
        end
        mismatches <= fail_count;
        pending <= expected_class_q.size();
    end

endmodule

>>> verif/directed_euler_classifier_tb.sv
// Testbench top for the directed Euler classifier: graph stimulus, output pacing, verdict.
module directed_euler_classifier_tb;
    import dec_pkg::*;

    localparam int NV             = MAX_VERTICES;
    localparam int SETTLE_CYCLES  = 320;     // covers the classify latency after the last row
    localparam int CHOKE_CYCLES   = 2500;    // long output hold-off, stalls the block at emit
    localparam int DRAIN_LIMIT    = 20000;
    localparam int ROWS_PER_PHASE = 90;
    localparam int PLANNED        = 11;      // fixed vertex counts; one random phase follows

    typedef struct {
        logic [VTX_W-1:0] idx;
        logic [NV-1:0]    bits;
    } row_beat_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic               cfg_ready;
    logic [CNT_W-1:0]   cfg_data    = '0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [VTX_W-1:0]   row_index   = '0;
    logic [NV-1:0]      row_bits    = '0;
    logic               last_row    = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [CLASS_W-1:0] euler_class;

    int mismatches;
    int pending;

    bit steady    = 1'b0;    // both sides stop idling while set
    bit choke_req = 1'b0;    // ask the receiver for one long hold-off

    int rows_sent   = 0;
    int graphs_sent = 0;
    int cfg_writes  = 0;

    logic [NV-1:0]    graph_rows [NV];
    logic [CNT_W-1:0] vcount_plan [PLANNED] =
        '{5'd16, 5'd1, 5'd4, 5'd31, 5'd2, 5'd0, 5'd8, 5'd16, 5'd3, 5'd12, 5'd17};

    directed_euler_classifier u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .euler_class (euler_class)
    );

    euler_class_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .row_index   (row_index),
        .row_bits    (row_bits),
        .last_row    (last_row),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .euler_class (euler_class),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run: every row a last row, each result stalled.
    initial
    begin
        #(20_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: accept at random, except for one long counted hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (choke_req)
            begin
                choke_req = 1'b0;
                out_ready <= 1'b0;
                for (int k = 0; k < CHOKE_CYCLES; k++)
                    @(posedge clk);
            end
            out_ready <= steady || ($urandom_range(99) >= 36);
        end
    end

    // Offer one row beat and hold it until accepted. Valid is only dropped for a gap, so a
    // back-to-back beat never sees valid lowered and raised in the same step.
    task automatic send_row(input logic [VTX_W-1:0] idx, input logic [NV-1:0] bits,
                            input logic last);
        if (!steady && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 36)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        row_index <= idx;
        row_bits  <= bits;
        last_row  <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        rows_sent++;
    endtask

    // Drain every outstanding result, let the block settle, then write the vertex count.
    task automatic write_vertex_count(input logic [CNT_W-1:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Build one graph over n vertices and send its rows, the final beat marked last.
    // Most graphs are Euler circuits, or circuits with one edge dropped or added, so the
    // classification gets past the connectivity check; the rest are random or lone rows.
    task automatic send_graph(input int n);
        int            order [NV];
        row_beat_t     beats [$];
        row_beat_t     beat;
        logic [NV-1:0] mask;
        int            pick;
        int            v;
        int            j;
        int            t;
        int            a;
        int            b;
        int            c;
        mask = '0;
        for (v = 0; v < n; v++)
            mask[v] = 1'b1;
        for (v = 0; v < NV; v++)
            graph_rows[v] = '0;
        pick = $urandom_range(99);
        if (pick >= 90)
        begin
            // noise: one lone row that closes the graph
            beat.idx  = VTX_W'($urandom_range(NV - 1));
            beat.bits = NV'($urandom);
            beats.insert(beats.size(), beat);
        end
        else
        begin
            if (pick < 72)
            begin
                // Hamiltonian cycle through a shuffled vertex order
                for (v = 0; v < n; v++)
                    order[v] = v;
                for (v = n - 1; v > 0; v--)
                begin
                    j = $urandom_range(v);
                    t = order[v];
                    order[v] = order[j];
                    order[j] = t;
                end
                for (v = 0; v < n; v++)
                    graph_rows[order[v]][order[(v + 1) % n]] = 1'b1;
                // add balanced extras: self loops, or triangles on fresh edges only
                repeat ($urandom_range(3))
                begin
                    a = $urandom_range(n - 1);
                    b = $urandom_range(n - 1);
                    c = $urandom_range(n - 1);
                    if (a == b && b == c)
                        graph_rows[a][a] = 1'b1;
                    else if (!graph_rows[a][b] && !graph_rows[b][c] && !graph_rows[c][a])
                    begin
                        graph_rows[a][b] = 1'b1;
                        graph_rows[b][c] = 1'b1;
                        graph_rows[c][a] = 1'b1;
                    end
                end
                if (pick >= 35 && pick < 60)
                begin
                    // drop one edge: every row holds at least its cycle edge
                    v = $urandom_range(n - 1);
                    j = $urandom_range(n - 1);
                    while (!graph_rows[v][j])
                        j = (j + 1) % n;
                    graph_rows[v][j] = 1'b0;
                end
                else if (pick >= 60)
                    graph_rows[$urandom_range(n - 1)][$urandom_range(n - 1)] = 1'b1;
            end
            else
            begin
                for (v = 0; v < n; v++)
                    graph_rows[v] = (pick < 80) ? NV'($urandom)
                                                : NV'($urandom & $urandom & $urandom);
            end
            // send rows in shuffled order; skip some empty rows, rewrite some rows,
            // and pad in-use rows with bits above the vertex count
            for (v = 0; v < n; v++)
                order[v] = v;
            for (v = n - 1; v > 0; v--)
            begin
                j = $urandom_range(v);
                t = order[v];
                order[v] = order[j];
                order[j] = t;
            end
            for (t = 0; t < n; t++)
            begin
                v = order[t];
                if (graph_rows[v] == '0 && $urandom_range(1) == 1)
                    continue;
                if ($urandom_range(9) == 0)
                begin
                    beat.idx  = VTX_W'(v);
                    beat.bits = NV'($urandom);
                    beats.insert(beats.size(), beat);
                end
                beat.idx  = VTX_W'(v);
                beat.bits = graph_rows[v] |
                            (($urandom_range(1) == 1) ? (NV'($urandom) & ~mask) : '0);
                beats.insert(beats.size(), beat);
            end
            // rows beyond the vertex count are stored but must not count
            if (n < NV && $urandom_range(4) == 0)
            begin
                beat.idx  = VTX_W'($urandom_range(NV - 1, n));
                beat.bits = NV'($urandom);
                beats.insert($urandom_range(beats.size()), beat);
            end
            if (beats.size() == 0)
            begin
                beat.idx  = '0;
                beat.bits = '0;
                beats.insert(beats.size(), beat);
            end
        end
        for (t = 0; t < beats.size(); t++)
            send_row(beats[t].idx, beats[t].bits, t == beats.size() - 1);
        graphs_sent++;
    endtask

    initial
    begin
        logic [CNT_W-1:0] value;
        int               n;
        int               p;
        int               k;
        int               phase_start;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed graphs. Reset count of 16: a lone empty row leaves vertices isolated.
        send_row(4'd5, 16'h0000, 1'b1);
        graphs_sent++;
        // one vertex: self loop counts once each way, high bits ignored
        write_vertex_count(5'd1);
        send_row(4'd0, 16'hFFFF, 1'b1);
        graphs_sent++;
        // count of zero acts as one; a single vertex alone is connected
        write_vertex_count(5'd0);
        send_row(4'd0, 16'h0000, 1'b1);
        graphs_sent++;
        // two vertices: circuit, path, rewritten row, self loop plus edge
        write_vertex_count(5'd2);
        send_row(4'd0, 16'h0002, 1'b0);
        send_row(4'd1, 16'h0001, 1'b1);
        send_row(4'd0, 16'h0002, 1'b1);
        send_row(4'd1, 16'hFFFF, 1'b0);
        send_row(4'd1, 16'h0000, 1'b0);
        send_row(4'd0, 16'h0002, 1'b1);
        send_row(4'd0, 16'h0003, 1'b1);
        graphs_sent += 4;
        // count above the store saturates to 16: complete graph with self loops
        write_vertex_count(5'd31);
        for (k = 0; k < NV; k++)
            send_row(VTX_W'(k), 16'hFFFF, k == NV - 1);
        graphs_sent++;

        // Random phases, one vertex count each. Phase 3 opens with the long output
        // hold-off while rows keep coming; phases 6 and 7 run with no idling at all.
        for (p = 0; p <= PLANNED; p++)
        begin
            value = (p < PLANNED) ? vcount_plan[p] : CNT_W'($urandom_range(31));
            write_vertex_count(value);
            n = (value == 0) ? 1 : ((value > NV) ? NV : int'(value));
            steady = (p == 6 || p == 7);
            if (p == 3)
                choke_req = 1'b1;
            phase_start = rows_sent;
            while (rows_sent - phase_start < ROWS_PER_PHASE)
                send_graph(n);
        end
        steady = 1'b0;

        // Drain: wait for every expected class, then give the block its latency again.
        in_valid <= 1'b0;
        @(posedge clk);
        for (k = 0; k < DRAIN_LIMIT && pending != 0; k++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending != 0)
            $error("%0d expected euler_class results never arrived", pending);

        $display("Run: %0d row beats in %0d graphs under %0d vertex-count writes",
                 rows_sent, graphs_sent, cfg_writes);
        $display("Run: counts 0, 1, 16, 31 too, one %0d-cycle output hold-off, no-idle stretch",
                 CHOKE_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
